/* src/rmth_pkg.sv */
// Shared types and constants for the running median block.
// No dependencies.
package rmth_pkg;
   localparam int HEAP_DEPTH_DEFAULT = 512;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_RT_READ,
      ST_RT_CMP,
      ST_PUSH_WR,
      ST_PUSH_READ,
      ST_PUSH_CMP,
      ST_TOPS,
      ST_TOPS_WAIT,
      ST_RESULT
   } state_type;
endpackage

/* src/rmth_if.sv */
// Valid/ready channel carrying one beat of payload.
// Depends on nothing.
interface rmth_if #(parameter int W = 32) (input logic clock);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* src/rmth_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
module rmth_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule

/* src/running_median_two_heaps.sv */
// Running median over two heaps held in RAMs; uses rmth_pkg, rmth_if, rmth_ram.
// A beat into an empty heap is written straight to its top; otherwise it is pushed and
// sifted up level by level. A top moved between heaps adds a replace-top sift-down,
// with the upper top fetched first when needed. Only one beat is in flight, set by
// the one port on each heap RAM; the next beat is taken the cycle after the result
// is registered. Reset clears the counts and the sequencer; heap RAMs need no clearing.
module running_median_two_heaps #(
   parameter int HEAP_DEPTH = rmth_pkg::HEAP_DEPTH_DEFAULT
) (
   input logic clock,
   input logic reset,
   rmth_if.sink   req,
   rmth_if.source rsp
);
   import rmth_pkg::*;
   localparam int AW = $clog2(HEAP_DEPTH);
   localparam int CW = $clog2(HEAP_DEPTH + 1);

   state_type state_ff, state_in;
   logic [CW-1:0] lcnt_ff, lcnt_in, ucnt_ff, ucnt_in;
   logic signed [31:0] s_ff, s_in, mv_ff, mv_in, cur_ff, cur_in;
   logic signed [31:0] lchild_ff, lchild_in;
   logic [CW:0] idx_ff, idx_in;
   logic side_ff, side_in;     // 1: operate on lower (max) heap
   logic pend_ff, pend_in;     // push follows replace-top
   logic rej_ff, rej_in, phase_ff, phase_in;
   logic [44:0] out_ff, out_in;
   logic ov_ff, ov_in;

   logic we_l, we_u;
   logic [AW-1:0] a_l, a_u, addr;
   logic signed [31:0] wd, rd_l, rd_u, rd;
   logic we;

   rmth_ram #(.WIDTH(32), .DEPTH(HEAP_DEPTH)) u_lo (
      .clock(clock), .we(we_l), .addr(a_l), .wdata(wd), .rdata(rd_l));
   rmth_ram #(.WIDTH(32), .DEPTH(HEAP_DEPTH)) u_up (
      .clock(clock), .we(we_u), .addr(a_u), .wdata(wd), .rdata(rd_u));

   assign rd = side_ff ? rd_l : rd_u;
   logic [CW-1:0] cnt_sel;
   assign cnt_sel = side_ff ? lcnt_ff : ucnt_ff;

   // compare helper: a above b for current heap
   function automatic logic above(input logic mx, input logic signed [31:0] a, b);
      above = mx ? (a > b) : (a < b);
   endfunction

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = ov_ff;
   assign rsp.data = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         lcnt_ff <= '0;
         ucnt_ff <= '0;
         ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         lcnt_ff <= lcnt_in;
         ucnt_ff <= ucnt_in;
         ov_ff <= ov_in;
      end
      s_ff <= s_in; mv_ff <= mv_in; cur_ff <= cur_in;
      lchild_ff <= lchild_in; idx_ff <= idx_in; side_ff <= side_in;
      pend_ff <= pend_in; rej_ff <= rej_in; phase_ff <= phase_in; out_ff <= out_in;
   end

   always_comb begin
      logic [CW:0] par, l, r, tot;
      logic signed [32:0] med;
      state_in = state_ff; lcnt_in = lcnt_ff; ucnt_in = ucnt_ff;
      s_in = s_ff; mv_in = mv_ff; cur_in = cur_ff;
      lchild_in = lchild_ff; idx_in = idx_ff; side_in = side_ff; pend_in = pend_ff;
      rej_in = rej_ff; phase_in = phase_ff; out_in = out_ff; ov_in = ov_ff;
      we = 1'b0; addr = '0; wd = cur_ff;
      par = (idx_ff - 1'b1) >> 1;
      l = {idx_ff[CW-1:0], 1'b1};
      r = l + 1'b1;
      tot = {1'b0, lcnt_ff} + {1'b0, ucnt_ff};
      med = '0;
      if (ov_ff && rsp.ready) ov_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // fetch lower top alongside the accepted beat
            side_in = 1'b1;
            if (req.valid) begin
               s_in = $signed(req.data[31:0]);
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            // rd holds lower top (addr 0)
            rej_in = 1'b0; pend_in = 1'b0; cur_in = s_ff; idx_in = '0;
            if (tot >= (CW+1)'(2*HEAP_DEPTH)) begin
               rej_in = 1'b1; state_in = ST_TOPS;
            end else if (lcnt_ff == '0 || s_ff <= rd_l) begin
               if (lcnt_ff > ucnt_ff) begin
                  mv_in = rd_l; side_in = 1'b1; pend_in = 1'b1; phase_in = 1'b0;
                  state_in = ST_RT_READ;
               end else begin
                  side_in = 1'b1; state_in = ST_PUSH_WR;
               end
            end else if (lcnt_ff > ucnt_ff) begin
               side_in = 1'b0; state_in = ST_PUSH_WR;
            end else begin
               // need upper top: read it, then decide
               side_in = 1'b0; state_in = ST_RT_READ; phase_in = 1'b1;
               addr = '0;
            end
         end
         ST_RT_READ: begin
            // replace-top sift: read left then right child
            if (phase_ff) begin
               // upper-top compare stage: issue read at 0
               addr = '0; state_in = ST_RT_CMP;
            end else if (l >= {1'b0, cnt_sel}) begin
               // place the value unless it already landed in the last compare
               we = (idx_ff < {1'b0, cnt_sel}); addr = idx_ff[AW-1:0];
               state_in = ST_PUSH_WR; side_in = ~side_ff; cur_in = mv_ff;
               idx_in = '0; pend_in = 1'b0;
            end else begin
               addr = l[AW-1:0]; state_in = ST_RT_CMP;
            end
         end
         ST_RT_CMP: begin
            if (phase_ff) begin
               // rd_u = upper top
               phase_in = 1'b0;
               if (ucnt_ff != '0 && s_ff > rd_u) begin
                  mv_in = rd_u; pend_in = 1'b1; state_in = ST_RT_READ;
               end else begin
                  side_in = 1'b1; state_in = ST_PUSH_WR;
               end
            end else if (!pend_ff) begin
               // second child beat: rd is right child
               if (above(side_ff, rd, lchild_ff) && above(side_ff, rd, cur_ff)) begin
                  we = 1'b1; addr = idx_ff[AW-1:0]; wd = rd; idx_in = r;
               end else if (above(side_ff, lchild_ff, cur_ff)) begin
                  we = 1'b1; addr = idx_ff[AW-1:0]; wd = lchild_ff; idx_in = l;
               end else begin
                  we = 1'b1; addr = idx_ff[AW-1:0]; idx_in = {1'b0, cnt_sel};
               end
               pend_in = 1'b1; state_in = ST_RT_READ;
            end else begin
               lchild_in = rd;
               if (r < {1'b0, cnt_sel}) begin
                  addr = r[AW-1:0]; pend_in = 1'b0;
               end else begin
                  if (above(side_ff, rd, cur_ff)) begin
                     we = 1'b1; addr = idx_ff[AW-1:0]; wd = rd; idx_in = l;
                  end else begin
                     we = 1'b1; addr = idx_ff[AW-1:0]; idx_in = {1'b0, cnt_sel};
                  end
                  state_in = ST_RT_READ;
               end
            end
         end
         ST_PUSH_WR: begin
            // start sift-up from the new slot
            idx_in = {1'b0, cnt_sel};
            if (side_ff) lcnt_in = lcnt_ff + 1'b1; else ucnt_in = ucnt_ff + 1'b1;
            state_in = ST_PUSH_READ;
            if (cnt_sel == '0) begin
               we = 1'b1; addr = '0; state_in = ST_TOPS;
            end
         end
         ST_PUSH_READ: begin
            addr = par[AW-1:0]; state_in = ST_PUSH_CMP;
         end
         ST_PUSH_CMP: begin
            // move parent down while the value rises
            if (above(side_ff, cur_ff, rd)) begin
               we = 1'b1; addr = idx_ff[AW-1:0]; wd = rd; idx_in = par;
               if (par == '0) begin
                  idx_in = '0; state_in = ST_TOPS_WAIT;
               end else state_in = ST_PUSH_READ;
            end else begin
               we = 1'b1; addr = idx_ff[AW-1:0]; state_in = ST_TOPS;
            end
         end
         ST_TOPS_WAIT: begin
            we = 1'b1; addr = '0; state_in = ST_TOPS;
         end
         ST_TOPS: begin
            addr = '0; state_in = ST_RESULT;
         end
         ST_RESULT: begin
            // both RAMs read slot 0; hold while the previous result still waits
            if (!ov_ff || rsp.ready) begin
               if (tot == '0) med = '0;
               else if (tot[0]) med = {rd_l, 1'b0};
               else med = 33'(rd_l) + 33'(rd_u);
               out_in = {rej_ff, 11'(tot), med};
               ov_in = 1'b1; side_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // port steering: idle/tops states read both heaps at slot 0
   always_comb begin
      we_l = we && side_ff;
      we_u = we && !side_ff;
      a_l = side_ff ? addr : '0;
      a_u = side_ff ? '0 : addr;
      if (state_ff == ST_DECIDE) begin
         a_u = '0; a_l = '0;
      end
   end
endmodule

/* verif/running_median_two_heaps_tb.sv */
// Testbench for running_median_two_heaps: random and directed samples, sorted-list predictor.
// Depends on rmth_pkg, rmth_if and the running_median_two_heaps RTL.
module running_median_two_heaps_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rmth_pkg::*;

   localparam int DEPTH    = HEAP_DEPTH_DEFAULT;
   localparam int RSP_W    = 45;
   localparam int WD_LIMIT = 20000;

   typedef struct {
      logic        hold;
      logic [31:0] sample;
   } pending_type;

   typedef struct {
      logic signed [32:0] median_doubled;
      logic [10:0]        sample_count;
      logic               rejected_full;
   } median_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rmth_if #(.W(32))    req (clock);
   rmth_if #(.W(RSP_W)) rsp (clock);

   running_median_two_heaps #(.HEAP_DEPTH(DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .req(req),
      .rsp(rsp)
   );

   pending_type sample_q[$];
   median_type  median_q[$];
   int signed   sorted_set[$];
   int          mismatches = 0;
   int          beats_sent = 0;
   int          idle_cycles = 0;
   bit          failed = 1'b0;

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Insert the sample into the sorted set and report twice the median.
   function automatic median_type predict_median(input logic [31:0] raw);
      median_type  m;
      int signed   s;
      int          pos;
      int          n;
      longint      lo;
      longint      hi;
      s = int'(raw);
      m.rejected_full = (sorted_set.size() >= 2 * DEPTH);
      if (!m.rejected_full) begin
         pos = 0;
         while (pos < sorted_set.size() && sorted_set[pos] <= s) pos++;
         sorted_set.insert(pos, s);
      end
      n = sorted_set.size();
      lo = longint'(sorted_set[(n - 1) / 2]);
      hi = longint'(sorted_set[n / 2]);
      m.median_doubled = 33'(lo + hi);
      m.sample_count = 11'(n);
      return m;
   endfunction

   // 36 percent idling, none inside the quiet stretch
   function automatic bit idle_roll();
      if (beats_sent >= 300 && beats_sent < 420) return 1'b0;
      return ($urandom_range(99) < 36);
   endfunction

   // Driver: predict on each accepted beat, then present the next one.
   always @(posedge clock) begin
      logic        next_valid;
      logic [31:0] next_data;
      pending_type head;
      if (reset) begin
         req.valid <= 1'b0;
         req.data  <= '0;
      end else begin
         next_valid = req.valid;
         next_data  = req.data;
         if (req.valid && req.ready) begin
            median_q.push_back(predict_median(req.data));
            beats_sent++;
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            // hold off until every outstanding result is back
            if (sample_q.size() > 0 && sample_q[0].hold && median_q.size() == 0 &&
                !(req.valid && req.ready))
               void'(sample_q.pop_front());
            if (sample_q.size() > 0 && !sample_q[0].hold && !idle_roll()) begin
               head       = sample_q.pop_front();
               next_valid = 1'b1;
               next_data  = head.sample;
            end
         end
         req.valid <= next_valid;
         req.data  <= next_data;
      end
   end

   // Monitor: compare each result beat with the oldest prediction.
   always @(posedge clock) begin
      median_type got;
      median_type exp_m;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            got.median_doubled = rsp.data[32:0];
            got.sample_count   = rsp.data[43:33];
            got.rejected_full  = rsp.data[44];
            if (median_q.size() == 0) begin
               failed = 1'b1;
               if (mismatches < 10)
                  $display("unexpected result beat: median2=%0d count=%0d rej=%0b",
                           got.median_doubled, got.sample_count, got.rejected_full);
               mismatches++;
            end else begin
               exp_m = median_q.pop_front();
               if (got.median_doubled !== exp_m.median_doubled ||
                   got.sample_count !== exp_m.sample_count ||
                   got.rejected_full !== exp_m.rejected_full) begin
                  failed = 1'b1;
                  if (mismatches < 10)
                     $display("mismatch: exp median2=%0d count=%0d rej=%0b, got %0d %0d %0b",
                              exp_m.median_doubled, exp_m.sample_count, exp_m.rejected_full,
                              got.median_doubled, got.sample_count, got.rejected_full);
                  mismatches++;
               end
            end
         end
         rsp.ready <= !idle_roll();
      end
   end

   // Watchdog: count cycles in which no beat moves on either side.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WD_LIMIT) begin
            $display("watchdog expired");
            $display("running_median_two_heaps test failed");
            $finish;
         end
      end
   end

   task automatic add_sample(input logic [31:0] s);
      pending_type p;
      p.hold = 1'b0;
      p.sample = s;
      sample_q.push_back(p);
   endtask

   task automatic add_hold();
      pending_type p;
      p.hold = 1'b1;
      p.sample = '0;
      sample_q.push_back(p);
   endtask

   function automatic logic [31:0] random_sample();
      int unsigned sel;
      sel = $urandom_range(9);
      case (sel)
         0: return 32'h8000_0000 + $urandom_range(3);
         1: return 32'h7fff_ffff - $urandom_range(3);
         2, 3: return 32'($urandom_range(20)) - 32'd10;
         default: return $urandom();
      endcase
   endfunction

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // extremes: both tops at max, both at min, mixed signs, ties
      add_sample(32'h7fff_ffff);
      add_sample(32'h7fff_ffff);
      add_sample(32'h8000_0000);
      add_sample(32'h8000_0000);
      add_sample(32'h8000_0000);
      add_sample(32'h0000_0000);
      add_sample(32'hffff_ffff);
      add_sample(32'h0000_0001);
      add_sample(32'h0000_0001);
      add_sample(32'h0000_0001);
      for (int i = 0; i < 6; i++) add_sample(32'(i * 1000));
      for (int i = 0; i < 6; i++) add_sample(32'(-i * 1000));
      add_sample(32'h5555_5555);
      add_sample(32'haaaa_aaaa);
      add_hold();

      // random mix, with a drain pause midway
      for (int i = 0; i < 676; i++) begin
         add_sample(random_sample());
         if (i == 338) add_hold();
      end

      while (sample_q.size() != 0 || req.valid || median_q.size() != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
      if (!failed && median_q.size() == 0) begin
         $display("running_median_two_heaps test passed");
      end else begin
         $display("running_median_two_heaps test failed");
      end
      $finish;
   end
endmodule
